[src/wa_pkg.sv]
// Shared types and constants for the word-analogy argmax search block.
// Used by the controller, the datapath and the divider.
package wa_pkg;

  // Fixed field widths of the stream payload and the configuration registers
  localparam int FIELD_WORD_W = 10;
  localparam int FIELD_ELEM_W = 7;
  localparam int FIELD_VAL_W  = 16;
  localparam int IN_DATA_W    = 64;
  localparam int OUT_DATA_W   = 24;
  localparam int CFG_DATA_W   = 11;
  localparam int LIMIT_W      = 11;
  localparam int LENGTH_W     = 8;

  // Field offsets within s_tdata
  localparam int OFS_LOAD_WORD = 0;
  localparam int OFS_LOAD_ELEM = 10;
  localparam int OFS_VALUE     = 17;
  localparam int OFS_WORD_A    = 33;
  localparam int OFS_WORD_B    = 43;
  localparam int OFS_WORD_C    = 53;

  // Score arithmetic
  localparam int SIM_W = 32;
  localparam int ADD_W = 34;
  localparam int NUM_W = 64;
  localparam int DEN_W = 47;
  localparam int Q_W   = 32;
  localparam int DEN_SHIFT = 14;
  localparam logic signed [SIM_W:0] EPS_Q30 = 33'sd1073742;
  localparam logic signed [SIM_W:0] HALF_Q30 = 33'sd1073741824;

  localparam int DRAIN_CYCLES = 2;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_code_t;

  typedef enum logic {
    CFG_VOCAB_LIMIT   = 1'b0,
    CFG_VECTOR_LENGTH = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SLOT_A = 2'd0,
    SLOT_B = 2'd1,
    SLOT_C = 2'd2
  } slot_t;

  typedef struct packed {
    logic  latch_in;
    logic  best_clr;
    logic  mem_we;
    logic  copy_rd;
    slot_t copy_slot;
    logic  scan_rd;
    logic  acc_clr;
    logic  score_sims;
    logic  score_mul;
    logic  div_start;
    logic  cmp;
    logic  emit;
  } wa_cmd_t;

  typedef struct packed {
    logic skip;
    logic div_done;
  } wa_stat_t;

endpackage

[src/wa_div.sv]
// Iterative signed divider for the multiplicative score, one quotient bit per cycle.
// Truncates toward zero and saturates to 32 bits. Uses wa_pkg.
module wa_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [wa_pkg::NUM_W-1:0]  num,
  input  logic signed [wa_pkg::DEN_W-1:0]  den,
  output logic                             done,
  output logic signed [wa_pkg::Q_W-1:0]    quo
);

  localparam int MAG_W = wa_pkg::NUM_W - 1;
  localparam int D_W   = wa_pkg::DEN_W;
  localparam int CNT_W = $clog2(MAG_W);
  localparam logic [MAG_W-1:0] POS_LIM = MAG_W'(32'h7FFF_FFFF);
  localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(33'h0_8000_0000);

  logic             busy;
  logic             fin;
  logic [CNT_W-1:0] cnt;
  logic [D_W-1:0]   rem;
  logic [D_W-1:0]   dmag;
  logic [MAG_W-1:0] nmag;
  logic             neg;
  logic [D_W:0]     trial;
  logic             fits;

  assign trial = {rem, nmag[MAG_W-1]};
  assign fits  = trial >= {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        neg  <= num[wa_pkg::NUM_W-1] ^ den[D_W-1];
        nmag <= MAG_W'(num < 0 ? -num : num);
        dmag <= D_W'(den < 0 ? -den : den);
        rem  <= '0;
        cnt  <= '0;
        if (den == '0) begin
          // zero denominator: saturate by the numerator's sign
          done <= 1'b1;
          if (num > 0)      quo <= 32'sh7FFF_FFFF;
          else if (num < 0) quo <= 32'sh8000_0000;
          else              quo <= '0;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem  <= fits ? D_W'(trial - {1'b0, dmag}) : D_W'(trial);
        nmag <= {nmag[MAG_W-2:0], fits};
        cnt  <= cnt + 1'b1;
        if (32'(cnt) == MAG_W - 1) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
        if (!neg) quo <= (nmag > POS_LIM) ? 32'sh7FFF_FFFF : $signed(nmag[31:0]);
        else      quo <= (nmag > NEG_LIM) ? 32'sh8000_0000 : -$signed(nmag[31:0]);
      end
    end
  end

endmodule

[src/wa_datapath.sv]
// Datapath: embedding memory, query vector buffers, three MAC lanes, score units,
// best-index tracking and the result register. Uses wa_pkg and wa_div.
module wa_datapath #(
  parameter int MAX_WORDS      = 1024,
  parameter int MAX_DIM        = 128,
  parameter int COMPONENT_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  wa_pkg::wa_cmd_t                           cmd,
  output wa_pkg::wa_stat_t                          stat,
  input  logic [wa_pkg::IN_DATA_W-1:0]              in_data,
  input  logic [((MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1)-1:0] id,
  input  logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0]     idx,
  output logic [wa_pkg::OUT_DATA_W-1:0]             res
);

  localparam int WORD_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH  = MAX_WORDS * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CB     = COMPONENT_BITS;
  localparam int SH     = (CB < 16) ? 16 - CB : 0;
  localparam int ACC_W  = 33 + DIM_W;
  localparam int FW     = wa_pkg::FIELD_WORD_W;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - 1;

  // latched item
  logic [FW-1:0]                      ld_word, wa, wb, wc;
  logic [wa_pkg::FIELD_ELEM_W-1:0]    ld_elem;
  logic signed [wa_pkg::FIELD_VAL_W-1:0] ld_val;

  logic [CB-1:0]     mem [DEPTH];
  logic [CB-1:0]     rd_data;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [FW-1:0]     copy_word;
  logic              ld_ok, copy_zero;

  logic signed [15:0] qa [MAX_DIM];
  logic signed [15:0] qb [MAX_DIM];
  logic signed [15:0] qc [MAX_DIM];
  logic signed [15:0] qa_rd, qb_rd, qc_rd;

  logic              copy_v, copy_zero_r, scan_v, prod_v;
  wa_pkg::slot_t     copy_slot_r;
  logic [DIM_W-1:0]  copy_idx_r;
  logic signed [31:0] rd_wide;
  logic signed [15:0] rd16;
  logic signed [31:0] pa, pb, pc;
  logic signed [ACC_W-1:0] acc_a, acc_b, acc_c;

  logic signed [wa_pkg::SIM_W-1:0] sat_a, sat_b, sat_c;
  logic signed [wa_pkg::SIM_W:0]   hs_a, hs_b, hs_c;
  logic signed [wa_pkg::SIM_W-1:0] sa, sb, sc;
  logic signed [wa_pkg::ADD_W-1:0] add_r, top_add;
  logic signed [wa_pkg::NUM_W-1:0] num_r;
  logic signed [wa_pkg::DEN_W-1:0] den_r;
  logic signed [wa_pkg::SIM_W:0]   den_sum;
  logic signed [wa_pkg::Q_W-1:0]   quo, top_mul;
  logic                            have;
  logic [WORD_W-1:0]               best_add, best_mul;
  logic [FW-1:0]                   res_add, res_mul;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > SAT_HI)      return 32'sh7FFF_FFFF;
    else if (v < SAT_LO) return 32'sh8000_0000;
    else                 return 32'(v);
  endfunction

  // input latch
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      ld_word <= in_data[wa_pkg::OFS_LOAD_WORD +: FW];
      ld_elem <= in_data[wa_pkg::OFS_LOAD_ELEM +: wa_pkg::FIELD_ELEM_W];
      ld_val  <= $signed(in_data[wa_pkg::OFS_VALUE +: wa_pkg::FIELD_VAL_W]);
      wa      <= in_data[wa_pkg::OFS_WORD_A +: FW];
      wb      <= in_data[wa_pkg::OFS_WORD_B +: FW];
      wc      <= in_data[wa_pkg::OFS_WORD_C +: FW];
    end
  end

  assign ld_ok   = (32'(ld_word) < MAX_WORDS) && (32'(ld_elem) < MAX_DIM);
  assign wr_addr = ADDR_W'(ADDR_W'(ld_word) * ADDR_W'(MAX_DIM) + ADDR_W'(ld_elem));

  always_comb begin
    unique case (cmd.copy_slot)
      wa_pkg::SLOT_A: copy_word = wa;
      wa_pkg::SLOT_B: copy_word = wb;
      default:        copy_word = wc;
    endcase
  end

  assign copy_zero = 32'(copy_word) >= MAX_WORDS;
  assign rd_addr = cmd.scan_rd ?
                   ADDR_W'(ADDR_W'(id) * ADDR_W'(MAX_DIM) + ADDR_W'(idx)) :
                   ADDR_W'(ADDR_W'(copy_word) * ADDR_W'(MAX_DIM) + ADDR_W'(idx));

  // embedding memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.mem_we && ld_ok) mem[wr_addr] <= CB'($signed(ld_val) >>> SH);
    rd_data <= mem[rd_addr];
  end

  assign rd_wide = 32'($signed(rd_data));
  assign rd16    = 16'(rd_wide <<< SH);

  // query buffers
  always_ff @(posedge clk) begin
    if (copy_v) begin
      unique case (copy_slot_r)
        wa_pkg::SLOT_A: qa[copy_idx_r] <= copy_zero_r ? '0 : rd16;
        wa_pkg::SLOT_B: qb[copy_idx_r] <= copy_zero_r ? '0 : rd16;
        default:        qc[copy_idx_r] <= copy_zero_r ? '0 : rd16;
      endcase
    end
    qa_rd <= qa[idx];
    qb_rd <= qb[idx];
    qc_rd <= qc[idx];
  end

  always_ff @(posedge clk) begin
    copy_slot_r <= cmd.copy_slot;
    copy_idx_r  <= idx;
    copy_zero_r <= copy_zero;
    pa <= rd16 * qa_rd;
    pb <= rd16 * qb_rd;
    pc <= rd16 * qc_rd;
    if (rst) begin
      copy_v <= 1'b0;
      scan_v <= 1'b0;
      prod_v <= 1'b0;
    end else begin
      copy_v <= cmd.copy_rd;
      scan_v <= cmd.scan_rd;
      prod_v <= scan_v;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc_a <= '0;
      acc_b <= '0;
      acc_c <= '0;
    end else if (prod_v) begin
      acc_a <= acc_a + ACC_W'(pa);
      acc_b <= acc_b + ACC_W'(pb);
      acc_c <= acc_c + ACC_W'(pc);
    end
  end

  // score stages
  assign sat_a   = sat32(acc_a);
  assign sat_b   = sat32(acc_b);
  assign sat_c   = sat32(acc_c);
  assign hs_a    = 33'(sat_a) + wa_pkg::HALF_Q30;
  assign hs_b    = 33'(sat_b) + wa_pkg::HALF_Q30;
  assign hs_c    = 33'(sat_c) + wa_pkg::HALF_Q30;
  assign den_sum = 33'(sa) + wa_pkg::EPS_Q30;

  always_ff @(posedge clk) begin
    if (cmd.score_sims) begin
      add_r <= 34'(sat_b) - 34'(sat_a) + 34'(sat_c);
      sa <= hs_a[32:1];
      sb <= hs_b[32:1];
      sc <= hs_c[32:1];
    end
    if (cmd.score_mul) begin
      num_r <= 64'(sb) * 64'(sc);
      den_r <= {den_sum, {wa_pkg::DEN_SHIFT{1'b0}}};
    end
  end

  wa_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num_r),
    .den   (den_r),
    .done  (stat.div_done),
    .quo   (quo)
  );

  // best tracking; strict compare keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (rst || cmd.best_clr) begin
      have     <= 1'b0;
      best_add <= '0;
      best_mul <= '0;
    end else if (cmd.cmp) begin
      have <= 1'b1;
      if (!have || add_r > top_add) begin
        top_add  <= add_r;
        best_add <= id;
      end
      if (!have || quo > top_mul) begin
        top_mul  <= quo;
        best_mul <= id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res_add <= FW'(best_add);
      res_mul <= FW'(best_mul);
    end
  end

  assign res = {4'b0, res_mul, res_add};
  assign stat.skip = (32'(id) == 32'(wa)) || (32'(id) == 32'(wb)) || (32'(id) == 32'(wc));

endmodule

[src/wa_ctrl.sv]
// Controller: configuration registers, handshake and the query sequencer state machine.
// Drives the datapath through wa_pkg::wa_cmd_t and reads wa_pkg::wa_stat_t.
module wa_ctrl #(
  parameter int MAX_WORDS = 1024,
  parameter int MAX_DIM   = 128
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [wa_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                              s_tvalid,
  input  logic                              s_tuser,
  output logic                              s_tready,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output wa_pkg::wa_cmd_t                   cmd,
  input  wa_pkg::wa_stat_t                  stat,
  output logic [((MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1)-1:0] id_out,
  output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0]     idx
);

  localparam int WORD_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int IDW    = $clog2(MAX_WORDS + 1);
  localparam int LENW   = $clog2(MAX_DIM + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_COPY, ST_COPY_WAIT, ST_CAND, ST_SCAN, ST_DRAIN,
    ST_SIMS, ST_MUL, ST_DIV, ST_DIV_WAIT, ST_CMP, ST_DONE
  } state_t;

  state_t                         state;
  logic [wa_pkg::LIMIT_W-1:0]     vocab_limit;
  logic [wa_pkg::LENGTH_W-1:0]    vector_length;
  logic [IDW-1:0]                 limit_eff, id;
  logic [LENW-1:0]                len_eff;
  wa_pkg::slot_t                  slot;
  logic [1:0]                     dcnt;
  logic                           accept, idx_last, out_free;

  assign limit_eff = (32'(vocab_limit) > MAX_WORDS) ? IDW'(MAX_WORDS) : IDW'(vocab_limit);
  assign len_eff   = (32'(vector_length) > MAX_DIM) ? LENW'(MAX_DIM) : LENW'(vector_length);
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign idx_last  = 32'(idx) == 32'(len_eff) - 1;
  assign out_free  = !m_tvalid || m_tready;
  assign id_out    = WORD_W'(id);

  always_ff @(posedge clk) begin
    if (rst) begin
      vocab_limit   <= wa_pkg::LIMIT_W'(1024);
      vector_length <= wa_pkg::LENGTH_W'(128);
    end else if (cfg_we) begin
      unique case (wa_pkg::cfg_reg_t'(cfg_index))
        wa_pkg::CFG_VOCAB_LIMIT:   vocab_limit   <= cfg_wdata;
        wa_pkg::CFG_VECTOR_LENGTH: vector_length <= cfg_wdata[wa_pkg::LENGTH_W-1:0];
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    cmd.copy_slot  = slot;
    cmd.latch_in   = accept;
    cmd.best_clr   = accept && (s_tuser == wa_pkg::CMD_QUERY);
    cmd.mem_we     = (state == ST_LOAD);
    cmd.copy_rd    = (state == ST_COPY);
    cmd.scan_rd    = (state == ST_SCAN);
    cmd.acc_clr    = (state == ST_CAND);
    cmd.score_sims = (state == ST_SIMS);
    cmd.score_mul  = (state == ST_MUL);
    cmd.div_start  = (state == ST_DIV);
    cmd.cmp        = (state == ST_CMP);
    cmd.emit       = (state == ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      id       <= '0;
      idx      <= '0;
      slot     <= wa_pkg::SLOT_A;
      dcnt     <= '0;
    end else begin
      if (cmd.emit)    m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            id   <= '0;
            idx  <= '0;
            slot <= wa_pkg::SLOT_A;
            if (s_tuser == wa_pkg::CMD_LOAD) state <= ST_LOAD;
            else if (len_eff == '0)          state <= ST_CAND;
            else                             state <= ST_COPY;
          end
        end
        ST_LOAD: state <= ST_IDLE;
        ST_COPY: begin
          if (idx_last) begin
            idx <= '0;
            if (slot == wa_pkg::SLOT_C) state <= ST_COPY_WAIT;
            else slot <= wa_pkg::slot_t'(slot + 2'd1);
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_COPY_WAIT: state <= ST_CAND;
        ST_CAND: begin
          idx <= '0;
          if (id == limit_eff)     state <= ST_DONE;
          else if (stat.skip)      id <= id + 1'b1;
          else if (len_eff == '0)  state <= ST_SIMS;
          else                     state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (idx_last) begin
            dcnt  <= '0;
            state <= ST_DRAIN;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_DRAIN: begin
          // wait for the read and multiply stages to reach the accumulators
          dcnt <= dcnt + 1'b1;
          if (32'(dcnt) == wa_pkg::DRAIN_CYCLES - 1) state <= ST_SIMS;
        end
        ST_SIMS:     state <= ST_MUL;
        ST_MUL:      state <= ST_DIV;
        ST_DIV:      state <= ST_DIV_WAIT;
        ST_DIV_WAIT: if (stat.div_done) state <= ST_CMP;
        ST_CMP: begin
          id    <= id + 1'b1;
          state <= ST_CAND;
        end
        ST_DONE: if (out_free) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[src/word_analogy_argmax_search.sv]
// Word-analogy argmax search (3CosAdd and 3CosMul) over an embedding memory.
// One item is in flight at a time. A load item keeps the input closed until it is written.
// A query runs longer with L, the vector length, and N, the candidates scored, plus any
// output stall; a skipped word is stepped past without a scan. Reading one component a
// cycle from the embedding memory and the bit-serial score divider set the query's length.
// Reset is synchronous: it clears control state and restores both registers to
// their defaults; the embedding memory holds undefined data until written.
module word_analogy_argmax_search #(
  parameter int MAX_WORDS      = 1024,
  parameter int MAX_DIM        = 128,
  parameter int COMPONENT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // load_word, load_element, element_value, word_a, word_b, word_c, zero pad
  input  logic [wa_pkg::IN_DATA_W-1:0]      s_tdata,
  // command
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // best_additive, best_multiplicative, zero pad
  output logic [wa_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [wa_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int WORD_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  wa_pkg::wa_cmd_t  cmd;
  wa_pkg::wa_stat_t stat;
  logic [WORD_W-1:0] id;
  logic [DIM_W-1:0]  idx;

  wa_ctrl #(
    .MAX_WORDS (MAX_WORDS),
    .MAX_DIM   (MAX_DIM)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tuser   (s_tuser),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cmd       (cmd),
    .stat      (stat),
    .id_out    (id),
    .idx       (idx)
  );

  wa_datapath #(
    .MAX_WORDS      (MAX_WORDS),
    .MAX_DIM        (MAX_DIM),
    .COMPONENT_BITS (COMPONENT_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .in_data (s_tdata),
    .id      (id),
    .idx     (idx),
    .res     (m_tdata)
  );

  // a query keeps the input closed while it runs
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> !s_tready)
    else $error("input open right after a query item");

  // a load item closes the input, which reopens after the ST_LOAD write state
  a_load_len: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser |=> !s_tready ##1 s_tready)
    else $error("load item did not finish in two cycles");

  // result indexes name real words
  a_res_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (32'(m_tdata[9:0]) < MAX_WORDS) && (32'(m_tdata[19:10]) < MAX_WORDS))
    else $error("result index out of range");

endmodule

[tb/sv/tb_word_analogy_argmax_search.sv]
// Self-checking bench for word_analogy_argmax_search: loads embeddings, runs analogy queries
// under several limit/length settings and compares each answer with an in-bench predictor.
// Depends on wa_pkg and the word_analogy_argmax_search top level.
`timescale 1ns / 1ps

module tb_word_analogy_argmax_search;

  localparam int WORDS = 1024;
  localparam int DIM = 128;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam longint EPS_FIX = 1073742;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;

  typedef struct {
    wa_pkg::cmd_code_t cmd;
    logic [9:0] lw;
    logic [6:0] le;
    logic signed [15:0] val;
    logic [9:0] wa, wb, wc;
  } op_t;

  class analogy_scoreboard;
    logic signed [15:0] emb [WORDS*DIM];
    int unsigned limit_reg, length_reg;
    logic [19:0] answer_q[$];
    int mismatches, loads_seen, queries_seen, answers_seen;

    function new();
      limit_reg = 1024;
      length_reg = 128;
      foreach (emb[i]) emb[i] = '0;
      mismatches = 0;
      loads_seen = 0;
      queries_seen = 0;
      answers_seen = 0;
    endfunction

    function void set_reg(wa_pkg::cfg_reg_t idx, int unsigned v);
      if (idx == wa_pkg::CFG_VOCAB_LIMIT) limit_reg = v & 11'h7ff;
      else length_reg = v & 8'hff;
    endfunction

    function longint dot(int w1, int w2, int len);
      longint acc;
      acc = 0;
      for (int i = 0; i < len; i++)
        acc += longint'(emb[w1*DIM+i]) * longint'(emb[w2*DIM+i]);
      if (acc > I32_MAX) acc = I32_MAX;
      if (acc < I32_MIN) acc = I32_MIN;
      return acc;
    endfunction

    function longint halve(longint sim);
      longint x;
      x = sim + (64'sd1 << 30);
      return (x >= 0) ? x / 2 : -((-x + 1) / 2);
    endfunction

    function longint ratio(longint sa, longint sb, longint sc);
      longint num, den, q;
      num = sb * sc;
      den = (sa + EPS_FIX) * 16384;
      if (den == 0) return (num > 0) ? I32_MAX : ((num < 0) ? I32_MIN : 0);
      q = num / den;
      if (q > I32_MAX) q = I32_MAX;
      if (q < I32_MIN) q = I32_MIN;
      return q;
    endfunction

    function void note_item(op_t op);
      int lim, len, a, b, c;
      longint sa, sb, sc, add, mul, top_add, top_mul;
      bit have;
      logic [9:0] best_add, best_mul;
      if (op.cmd == wa_pkg::CMD_LOAD) begin
        emb[int'(op.lw)*DIM + int'(op.le)] = op.val;
        loads_seen++;
        return;
      end
      a = int'(op.wa);
      b = int'(op.wb);
      c = int'(op.wc);
      lim = (limit_reg > WORDS) ? WORDS : int'(limit_reg);
      len = (length_reg > DIM) ? DIM : int'(length_reg);
      have = 0;
      best_add = '0;
      best_mul = '0;
      top_add = 0;
      top_mul = 0;
      for (int id = 0; id < lim; id++) begin
        if (id == a || id == b || id == c) continue;
        sa = dot(id, a, len);
        sb = dot(id, b, len);
        sc = dot(id, c, len);
        add = sb - sa + sc;
        mul = ratio(halve(sa), halve(sb), halve(sc));
        if (!have || add > top_add) begin
          top_add = add;
          best_add = 10'(id);
        end
        if (!have || mul > top_mul) begin
          top_mul = mul;
          best_mul = 10'(id);
        end
        have = 1;
      end
      answer_q.insert(answer_q.size(), {best_mul, best_add});
      queries_seen++;
    endfunction

    function void check_result(logic [wa_pkg::OUT_DATA_W-1:0] d);
      logic [19:0] want;
      answers_seen++;
      if (answer_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected answer %h", d);
        return;
      end
      want = answer_q.pop_front();
      if (d[9:0] !== want[9:0]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("best_additive: expected %0d got %0d", want[9:0], d[9:0]);
      end
      if (d[19:10] !== want[19:10]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("best_multiplicative: expected %0d got %0d", want[19:10], d[19:10]);
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready, s_tuser;
  logic [wa_pkg::IN_DATA_W-1:0] s_tdata;
  logic m_tvalid, m_tready;
  logic [wa_pkg::OUT_DATA_W-1:0] m_tdata;
  logic cfg_we, cfg_index;
  logic [wa_pkg::CFG_DATA_W-1:0] cfg_wdata;

  word_analogy_argmax_search uut (.*);

  analogy_scoreboard sb = new();
  bit written [WORDS*DIM];
  bit quiet;
  int stall_left;
  longint cycle_count;
  int eff_len;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: check on handshake, stall in random bursts
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
    if (rst) begin
      m_tready <= 1'b0;
    end else if (quiet) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(0, 6);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send(op_t op);
    logic [wa_pkg::IN_DATA_W-1:0] data;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    data = '0;
    data[wa_pkg::OFS_LOAD_WORD +: 10] = op.lw;
    data[wa_pkg::OFS_LOAD_ELEM +: 7] = op.le;
    data[wa_pkg::OFS_VALUE +: 16] = op.val;
    data[wa_pkg::OFS_WORD_A +: 10] = op.wa;
    data[wa_pkg::OFS_WORD_B +: 10] = op.wb;
    data[wa_pkg::OFS_WORD_C +: 10] = op.wc;
    s_tvalid <= 1'b1;
    s_tuser <= op.cmd;
    s_tdata <= data;
    do @(posedge clk); while (!s_tready);
    sb.note_item(op);
  endtask

  function automatic logic signed [15:0] pick_value();
    unique case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic load(int w, int e, logic signed [15:0] v);
    op_t op;
    op.cmd = wa_pkg::CMD_LOAD;
    op.lw = 10'(w);
    op.le = 7'(e);
    op.val = v;
    op.wa = 10'($urandom);
    op.wb = 10'($urandom);
    op.wc = 10'($urandom);
    written[w*DIM+e] = 1;
    send(op);
  endtask

  task automatic query(int a, int b, int c);
    op_t op;
    op.cmd = wa_pkg::CMD_QUERY;
    op.lw = 10'($urandom);
    op.le = 7'($urandom);
    op.val = 16'($urandom);
    op.wa = 10'(a);
    op.wb = 10'(b);
    op.wc = 10'(c);
    send(op);
  endtask

  function automatic bit row_ready(int w);
    for (int e = 0; e < eff_len; e++)
      if (!written[w*DIM+e]) return 0;
    return 1;
  endfunction

  // any word whose row is fully written, else one from the filled block
  function automatic int pick_word(int hi);
    int w;
    w = $urandom_range(0, WORDS-1);
    if (!row_ready(w)) w = $urandom_range(0, hi);
    return w;
  endfunction

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.answer_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(int unsigned lim, int unsigned len);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= wa_pkg::CFG_VOCAB_LIMIT;
    cfg_wdata <= wa_pkg::CFG_DATA_W'(lim);
    @(posedge clk);
    sb.set_reg(wa_pkg::CFG_VOCAB_LIMIT, lim);
    cfg_index <= wa_pkg::CFG_VECTOR_LENGTH;
    cfg_wdata <= wa_pkg::CFG_DATA_W'(len);
    @(posedge clk);
    sb.set_reg(wa_pkg::CFG_VECTOR_LENGTH, len);
    cfg_we <= 1'b0;
    eff_len = (len > DIM) ? DIM : int'(len);
  endtask

  task automatic fill_rows(int rows);
    for (int w = 0; w < rows; w++)
      for (int e = 0; e < eff_len; e++)
        if (!written[w*DIM+e]) load(w, e, pick_value());
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_wdata = '0;
    quiet = 0;
    eff_len = DIM;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no candidates and zero length: answers are both zero
    set_config(0, 0);
    load(0, 0, 16'sh8000);
    load(1023, 127, 16'sh7fff);
    load(512, 64, 16'sh0000);
    query(0, 0, 0);
    query(1023, 512, 1);

    set_config(8, 4);
    fill_rows(10);
    for (int e = 0; e < 4; e++) load(7, e, sb.emb[6*DIM+e]);  // tie between rows 6 and 7
    query(0, 0, 0);
    query(1, 2, 3);
    query(9, 8, 0);
    drain();
    for (int i = 0; i < 4; i++) query(pick_word(9), pick_word(9), pick_word(9));

    // length above the maximum saturates; the copy loop must still end
    set_config(3, 255);
    query(0, 1, 2);

    // limit above the maximum saturates; zero length makes every candidate tie
    set_config(2047, 0);
    query(0, 1, 2);
    query(1023, 5, 0);

    set_config(12, 4);
    fill_rows(12);
    for (int i = 0; i < 40; i++) begin
      if (i == 30) quiet = 1;
      if (i == 15) drain();
      if ($urandom_range(0, 99) < 35)
        query(pick_word(11), pick_word(11), pick_word(11));
      else if ($urandom_range(0, 4) == 0)
        load($urandom_range(0, WORDS-1), $urandom_range(0, DIM-1), pick_value());
      else
        load($urandom_range(0, 11), $urandom_range(0, 3), pick_value());
    end

    s_tvalid <= 1'b0;
    while (sb.answer_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d loads and %0d queries, %0d answers checked",
             sb.loads_seen, sb.queries_seen, sb.answers_seen);
    $display("settings swept: limits 0/8/3/2047/12, lengths 0/4/255/0/4");
    if (sb.mismatches == 0 && sb.answer_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

[sim.f]
src/wa_pkg.sv
src/wa_div.sv
src/wa_datapath.sv
src/wa_ctrl.sv
src/word_analogy_argmax_search.sv
tb/sv/tb_word_analogy_argmax_search.sv
